// ===== design/tpfg_pkg.sv =====
// ----------------------------------------------------------------------------
// tpfg_pkg - shared definitions for the thermal pi frequency governor
// widths, register indexes, reset values and sequencer states
// ----------------------------------------------------------------------------
package tpfg_pkg;

   // field widths
   localparam int TempW   = 18;
   localparam int ClassW  = 2;
   localparam int FreqW   = 32;
   localparam int TsW     = 24;
   localparam int IntvW   = 8;
   localparam int SetW    = 50;
   localparam int GainW   = 60;
   localparam int CsrIdxW = 8;
   localparam int CsrDatW = 64;

   // sub-field widths of the tuning sets
   localparam int TgtW = 17;
   localparam int FfW  = 16;
   localparam int KW   = 20;
   localparam int TiW  = 16;
   localparam int F0W  = 24;

   // internal datapath widths
   localparam int ErrW  = 19;             // target minus temperature
   localparam int DiffW = 20;             // error change
   localparam int DtW   = 18;             // target minus reference temp
   localparam int DvdW  = KW + TsW;       // K*Ts dividend
   localparam int RemW  = TiW + 1;        // remainder, below 2*Ti
   localparam int CoefW = 31;             // saturated coefficient A
   localparam int MulAW = 32;
   localparam int MulBW = 25;
   localparam int MulPW = MulAW + MulBW;
   localparam int AccW  = 54;
   localparam int DivCntW = 6;
   localparam int DivSteps = DvdW;

   // reset values of the registers
   localparam logic [TsW-1:0]   TsReset   = 24'd1000000;
   localparam logic [SetW-1:0]  SetReset  = 50'd549764989008000;
   localparam logic [GainW-1:0] GainReset = 60'd97650376704020000;

   // coefficient and output limits
   localparam logic [CoefW-1:0]        CoefMax = {CoefW{1'b1}};
   localparam logic signed [AccW-1:0]  SumLow  = -(AccW'(64'sd2147483648));
   localparam logic signed [AccW-1:0]  SumHigh = AccW'(64'sd2147483647);
   localparam logic signed [FreqW-1:0] OutLow  = -(FreqW'(64'sd2147483647));
   localparam logic signed [FreqW-1:0] OutHigh = FreqW'(64'sd2147483646);

   // workload classes
   localparam logic [ClassW-1:0] ClassFloat = 2'd1;
   localparam logic [ClassW-1:0] ClassInt   = 2'd2;

   typedef enum logic [CsrIdxW-1:0] {
      REG_SAMPLE_PERIOD  = 8'd0,
      REG_CHECK_INTERVAL = 8'd1,
      REG_FLOAT_SETPTS   = 8'd2,
      REG_FLOAT_GAINS    = 8'd3,
      REG_INT_SETPTS     = 8'd4,
      REG_INT_GAINS      = 8'd5,
      REG_MEM_SETPTS     = 8'd6,
      REG_MEM_GAINS      = 8'd7
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KTS,
      ST_DIFF,
      ST_DT,
      ST_DIV,
      ST_PMUL,
      ST_FMUL,
      ST_ACC,
      ST_DONE
   } seq_state_type;

endpackage

// ===== design/thermal_pi_frequency_governor.sv =====
// ----------------------------------------------------------------------------
// thermal_pi_frequency_governor - incremental pi controller with feedforward
// one shared multiplier and one shared adder stepped by a small sequencer
// ----------------------------------------------------------------------------
// a request is accepted only in idle, so the next request waits until the sequencer
// has finished the current one; the 44-step restoring division of K*Ts by 2*Ti
//    on the shared adder is skipped when Ti is 0
// a finished result waits in the output register while the next request runs
// reset: synchronous, active high; registers return to their reset values,
//    controller history and class counter clear, no result pending
module thermal_pi_frequency_governor (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // temperature [17:0], class_sample [19:18]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // freq_target [31:0]
   output logic [0:0]  rsp_tuser,   // clamped [0]
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_data
);

   // ---------------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------------
   logic [tpfg_pkg::TsW-1:0]   ts_ff;
   logic [tpfg_pkg::IntvW-1:0] intv_ff;
   logic [tpfg_pkg::SetW-1:0]  setpts_ff [3];   // 0 float, 1 int, 2 mem
   logic [tpfg_pkg::GainW-1:0] gains_ff  [3];

   // ---------------------------------------------------------------------
   // sequencer and datapath registers
   // ---------------------------------------------------------------------
   tpfg_pkg::seq_state_type state_ff, state_in;

   logic [tpfg_pkg::ClassW-1:0]      held_class_ff, held_class_in;
   logic [tpfg_pkg::IntvW-1:0]       check_count_ff, check_count_in;
   logic signed [tpfg_pkg::ErrW-1:0] prev_err_ff, prev_err_in;
   logic signed [tpfg_pkg::FreqW-1:0] prev_out_ff, prev_out_in;

   logic signed [tpfg_pkg::TempW-1:0] temp_ff, temp_in;
   logic signed [tpfg_pkg::ErrW-1:0]  err_ff, err_in;
   logic signed [tpfg_pkg::DiffW-1:0] diff_ff, diff_in;
   logic signed [tpfg_pkg::DtW-1:0]   dt_ff, dt_in;
   logic [tpfg_pkg::DvdW-1:0]         dq_ff, dq_in;      // dividend, then quotient
   logic [tpfg_pkg::RemW-1:0]         rem_ff, rem_in;
   logic [tpfg_pkg::DivCntW-1:0]      div_cnt_ff, div_cnt_in;
   logic signed [tpfg_pkg::AccW-1:0]  prod_ff, prod_in;
   logic signed [tpfg_pkg::AccW-1:0]  acc_ff, acc_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [tpfg_pkg::FreqW-1:0] rsp_freq_ff, rsp_freq_in;
   logic                              rsp_clamp_ff, rsp_clamp_in;

   // ---------------------------------------------------------------------
   // tuning set picked by the held class
   // ---------------------------------------------------------------------
   logic [1:0]                      set_sel;
   logic [tpfg_pkg::SetW-1:0]       cur_set;
   logic [tpfg_pkg::GainW-1:0]      cur_gain;
   logic [tpfg_pkg::TgtW-1:0]       tgt;
   logic [tpfg_pkg::TgtW-1:0]       t0;
   logic [tpfg_pkg::FfW-1:0]        ff_gain;
   logic [tpfg_pkg::KW-1:0]         k_gain;
   logic [tpfg_pkg::TiW-1:0]        ti;
   logic [tpfg_pkg::F0W-1:0]        f0;

   always_comb begin
      priority if (held_class_ff == tpfg_pkg::ClassFloat) begin
         set_sel = 2'd0;
      end else if (held_class_ff == tpfg_pkg::ClassInt) begin
         set_sel = 2'd1;
      end else begin
         set_sel = 2'd2;   // classes 0 and 3 run the mem set
      end
   end

   assign cur_set  = setpts_ff[set_sel];
   assign cur_gain = gains_ff[set_sel];
   assign tgt      = cur_set[16:0];
   assign t0       = cur_set[33:17];
   assign ff_gain  = cur_set[49:34];
   assign k_gain   = cur_gain[19:0];
   assign ti       = cur_gain[35:20];
   assign f0       = cur_gain[59:36];

   // ---------------------------------------------------------------------
   // shared units: one signed multiplier, one add/subtract
   // ---------------------------------------------------------------------
   logic signed [tpfg_pkg::MulAW-1:0] mul_a;
   logic signed [tpfg_pkg::MulBW-1:0] mul_b;
   logic signed [tpfg_pkg::MulPW-1:0] mul_p;
   logic signed [tpfg_pkg::AccW-1:0]  add_x, add_y, add_sum;
   logic                              add_sub;

   assign mul_p   = mul_a * mul_b;
   assign add_sum = add_sub ? (add_x - add_y) : (add_x + add_y);

   // division step: shift next dividend bit into the remainder and trial subtract
   logic [tpfg_pkg::RemW:0]        trial;
   logic                           div_ge;
   logic [tpfg_pkg::CoefW-1:0]     coef;

   assign trial  = {rem_ff, dq_ff[tpfg_pkg::DvdW-1]};
   assign div_ge = !add_sum[tpfg_pkg::AccW-1];

   // saturated coefficient, Ti of zero gives the maximum
   always_comb begin
      if (ti == '0 || (|dq_ff[tpfg_pkg::DvdW-1:tpfg_pkg::CoefW])) begin
         coef = tpfg_pkg::CoefMax;
      end else begin
         coef = dq_ff[tpfg_pkg::CoefW-1:0];
      end
   end

   // clamp of the final sum
   logic                              clamp_lo, clamp_hi;
   assign clamp_lo = acc_ff <= tpfg_pkg::SumLow;
   assign clamp_hi = acc_ff >= tpfg_pkg::SumHigh;

   // class refresh on accept
   logic [tpfg_pkg::IntvW:0] cnt_next;
   assign cnt_next = {1'b0, check_count_ff} + 1'b1;

   logic req_fire;
   logic rsp_free;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // ---------------------------------------------------------------------
   // sequencer: next state, unit operand selection and register updates
   // ---------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      held_class_in  = held_class_ff;
      check_count_in = check_count_ff;
      prev_err_in    = prev_err_ff;
      prev_out_in    = prev_out_ff;
      temp_in        = temp_ff;
      err_in         = err_ff;
      diff_in        = diff_ff;
      dt_in          = dt_ff;
      dq_in          = dq_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      rsp_freq_in    = rsp_freq_ff;
      rsp_clamp_in   = rsp_clamp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      mul_a   = '0;
      mul_b   = '0;
      add_x   = acc_ff;
      add_y   = '0;
      add_sub = 1'b0;
      req_tready = 1'b0;

      unique case (state_ff)
         tpfg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_fire) begin
               temp_in = $signed(req_tdata[17:0]);
               if (cnt_next >= {1'b0, intv_ff}) begin
                  check_count_in = '0;
                  held_class_in  = req_tdata[19:18];
               end else begin
                  check_count_in = cnt_next[tpfg_pkg::IntvW-1:0];
               end
               state_in = tpfg_pkg::ST_KTS;
            end
         end
         tpfg_pkg::ST_KTS: begin
            // K*Ts on the multiplier, error on the adder
            mul_a   = $signed(tpfg_pkg::MulAW'(k_gain));
            mul_b   = $signed(tpfg_pkg::MulBW'(ts_ff));
            dq_in   = mul_p[tpfg_pkg::DvdW-1:0];
            add_x   = $signed(tpfg_pkg::AccW'(tgt));
            add_y   = tpfg_pkg::AccW'(temp_ff);
            add_sub = 1'b1;
            err_in  = add_sum[tpfg_pkg::ErrW-1:0];
            state_in = tpfg_pkg::ST_DIFF;
         end
         tpfg_pkg::ST_DIFF: begin
            add_x   = tpfg_pkg::AccW'(err_ff);
            add_y   = tpfg_pkg::AccW'(prev_err_ff);
            add_sub = 1'b1;
            diff_in = add_sum[tpfg_pkg::DiffW-1:0];
            state_in = tpfg_pkg::ST_DT;
         end
         tpfg_pkg::ST_DT: begin
            add_x      = $signed(tpfg_pkg::AccW'(tgt));
            add_y      = $signed(tpfg_pkg::AccW'(t0));
            add_sub    = 1'b1;
            dt_in      = add_sum[tpfg_pkg::DtW-1:0];
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = (ti == '0) ? tpfg_pkg::ST_PMUL : tpfg_pkg::ST_DIV;
         end
         tpfg_pkg::ST_DIV: begin
            add_x   = $signed(tpfg_pkg::AccW'(trial));
            add_y   = $signed(tpfg_pkg::AccW'({ti, 1'b0}));
            add_sub = 1'b1;
            rem_in  = div_ge ? add_sum[tpfg_pkg::RemW-1:0] : trial[tpfg_pkg::RemW-1:0];
            dq_in   = {dq_ff[tpfg_pkg::DvdW-2:0], div_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == tpfg_pkg::DivCntW'(tpfg_pkg::DivSteps - 1)) begin
               state_in = tpfg_pkg::ST_PMUL;
            end
         end
         tpfg_pkg::ST_PMUL: begin
            // proportional product; start the sum with previous output plus f0
            mul_a   = $signed({1'b0, coef});
            mul_b   = tpfg_pkg::MulBW'(diff_ff);
            prod_in = mul_p[tpfg_pkg::AccW-1:0];
            add_x   = tpfg_pkg::AccW'(prev_out_ff);
            add_y   = $signed(tpfg_pkg::AccW'(f0));
            acc_in  = add_sum;
            state_in = tpfg_pkg::ST_FMUL;
         end
         tpfg_pkg::ST_FMUL: begin
            // feedforward product while the proportional term is added
            mul_a   = $signed(tpfg_pkg::MulAW'(ff_gain));
            mul_b   = tpfg_pkg::MulBW'(dt_ff);
            prod_in = mul_p[tpfg_pkg::AccW-1:0];
            add_x   = acc_ff;
            add_y   = prod_ff;
            acc_in  = add_sum;
            state_in = tpfg_pkg::ST_ACC;
         end
         tpfg_pkg::ST_ACC: begin
            add_x   = acc_ff;
            add_y   = prod_ff;
            acc_in  = add_sum;
            state_in = tpfg_pkg::ST_DONE;
         end
         tpfg_pkg::ST_DONE: begin
            // hold until the output register can take the result
            if (rsp_free) begin
               priority if (clamp_lo) begin
                  rsp_freq_in  = tpfg_pkg::OutLow;
                  rsp_clamp_in = 1'b1;
               end else if (clamp_hi) begin
                  rsp_freq_in  = tpfg_pkg::OutHigh;
                  rsp_clamp_in = 1'b1;
               end else begin
                  rsp_freq_in  = acc_ff[tpfg_pkg::FreqW-1:0];
                  rsp_clamp_in = 1'b0;
               end
               prev_out_in  = rsp_freq_in;
               prev_err_in  = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = tpfg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpfg_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tpfg_pkg::ST_IDLE;
         held_class_ff  <= '0;
         check_count_ff <= '0;
         prev_err_ff    <= '0;
         prev_out_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         ts_ff          <= tpfg_pkg::TsReset;
         intv_ff        <= '0;
         for (int i = 0; i < 3; i++) begin
            setpts_ff[i] <= tpfg_pkg::SetReset;
            gains_ff[i]  <= tpfg_pkg::GainReset;
         end
      end else begin
         state_ff       <= state_in;
         held_class_ff  <= held_class_in;
         check_count_ff <= check_count_in;
         prev_err_ff    <= prev_err_in;
         prev_out_ff    <= prev_out_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               tpfg_pkg::REG_SAMPLE_PERIOD:  ts_ff   <= csr_data[tpfg_pkg::TsW-1:0];
               tpfg_pkg::REG_CHECK_INTERVAL: intv_ff <= csr_data[tpfg_pkg::IntvW-1:0];
               tpfg_pkg::REG_FLOAT_SETPTS:   setpts_ff[0] <= csr_data[tpfg_pkg::SetW-1:0];
               tpfg_pkg::REG_FLOAT_GAINS:    gains_ff[0]  <= csr_data[tpfg_pkg::GainW-1:0];
               tpfg_pkg::REG_INT_SETPTS:     setpts_ff[1] <= csr_data[tpfg_pkg::SetW-1:0];
               tpfg_pkg::REG_INT_GAINS:      gains_ff[1]  <= csr_data[tpfg_pkg::GainW-1:0];
               tpfg_pkg::REG_MEM_SETPTS:     setpts_ff[2] <= csr_data[tpfg_pkg::SetW-1:0];
               tpfg_pkg::REG_MEM_GAINS:      gains_ff[2]  <= csr_data[tpfg_pkg::GainW-1:0];
               default: ;   // unknown index, write dropped
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      temp_ff      <= temp_in;
      err_ff       <= err_in;
      diff_ff      <= diff_in;
      dt_ff        <= dt_in;
      dq_ff        <= dq_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      rsp_freq_ff  <= rsp_freq_in;
      rsp_clamp_ff <= rsp_clamp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_freq_ff;
   assign rsp_tuser  = rsp_clamp_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == tpfg_pkg::ST_KTS)
      else $error("accepted request did not start the sequencer");

   a_clamp_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata == tpfg_pkg::OutLow || rsp_tdata == tpfg_pkg::OutHigh)
      else $error("clamp flag without a limit value");

   a_prev_out_range: assert property (@(posedge clock) disable iff (reset)
      prev_out_ff != tpfg_pkg::SumLow[tpfg_pkg::FreqW-1:0] &&
      prev_out_ff != tpfg_pkg::SumHigh[tpfg_pkg::FreqW-1:0])
      else $error("stored output outside clamp range");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == tpfg_pkg::ST_DIV |->
         div_cnt_ff < tpfg_pkg::DivCntW'(tpfg_pkg::DivSteps))
      else $error("division ran past its step count");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == tpfg_pkg::ST_DIV && $past(state_ff) == tpfg_pkg::ST_DIV |->
         {1'b0, rem_ff} < {1'b0, ti, 1'b0})
      else $error("division remainder not below divisor");

endmodule
